// ===== src/lcd_4bit_over_shift_register_defines.svh =====
// Assertion macros shared by the LCD shift-register driver.
`ifndef LCD_4BIT_OVER_SHIFT_REGISTER_DEFINES_SVH
`define LCD_4BIT_OVER_SHIFT_REGISTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Antecedent holds: consequent must hold in the same cycle.
`define LCD4_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent holds: consequent must hold in the next cycle.
`define LCD4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LCD4_ASSERT_NOW(label, clk, rst, ante, cons)
`define LCD4_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/lcd4_pkg.sv =====
// Package: codes, control word type and microcode table of the LCD driver.
package lcd4_pkg;

   localparam int FRAME_BITS = 8;
   localparam int BIT_IDX_W  = $clog2(FRAME_BITS);
   localparam int ROM_DEPTH  = 7;
   localparam int STEP_W     = $clog2(ROM_DEPTH);

   localparam logic [2:0] FUNC_COMMAND = 3'd0;
   localparam logic [2:0] FUNC_DATA    = 3'd1;
   localparam logic [2:0] FUNC_CURSOR  = 3'd2;
   localparam logic [2:0] FUNC_CLEAR   = 3'd3;
   localparam logic [2:0] FUNC_GLYPH   = 3'd4;

   localparam logic [7:0] CURSOR_BASE = 8'h7F;
   localparam logic [7:0] GLYPH_BASE  = 8'h40;

   localparam logic [STEP_W-1:0] BYTE_ENTRY  = STEP_W'(0);
   localparam logic [STEP_W-1:0] CLEAR_ENTRY = STEP_W'(6);

   typedef enum logic {
      IDLE_STATE,
      RUN_STATE
   } seq_state_type;

   // One microcode step emits one frame.
   typedef struct packed {
      logic nib_low;   // send low nibble instead of high
      logic set_e;     // raise enable
      logic use_rs;    // raise register select when the request is data
      logic blank;     // all-zero frame
      logic stop;      // program ends after this frame
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      unique case (step)
         3'd0: w = '{nib_low: 1'b0, set_e: 1'b0, use_rs: 1'b0, blank: 1'b0, stop: 1'b0};
         3'd1: w = '{nib_low: 1'b0, set_e: 1'b1, use_rs: 1'b1, blank: 1'b0, stop: 1'b0};
         3'd2: w = '{nib_low: 1'b0, set_e: 1'b0, use_rs: 1'b1, blank: 1'b0, stop: 1'b0};
         3'd3: w = '{nib_low: 1'b1, set_e: 1'b0, use_rs: 1'b0, blank: 1'b0, stop: 1'b0};
         3'd4: w = '{nib_low: 1'b1, set_e: 1'b1, use_rs: 1'b1, blank: 1'b0, stop: 1'b0};
         3'd5: w = '{nib_low: 1'b1, set_e: 1'b0, use_rs: 1'b1, blank: 1'b0, stop: 1'b1};
         3'd6: w = '{nib_low: 1'b0, set_e: 1'b0, use_rs: 1'b0, blank: 1'b1, stop: 1'b1};
         default: w = '{nib_low: 1'b0, set_e: 1'b0, use_rs: 1'b0, blank: 1'b1, stop: 1'b1};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] row_offset(input logic [2:0] row);
      logic [7:0] off;
      off = 8'h00;
      unique case (row)
         3'd1: off = 8'h00;
         3'd2: off = 8'h40;
         3'd3: off = 8'h14;
         3'd4: off = 8'h54;
         default: off = 8'h00;
      endcase
      return off;
   endfunction

endpackage

// ===== src/lcd_4bit_over_shift_register.sv =====
// Top level: microcoded driver for a 4-bit character LCD behind a serial shift register.
// Latency: the first bit is offered the cycle after a request is taken; one bit per cycle
//   while rsp_stall is low. Command, data, cursor and glyph requests send the high and low
//   nibble frames of the byte, a clear one blank frame; a new request is taken only in idle.
// Requests that produce nothing (unused func, bad cursor row) are taken and dropped.
// Reset (synchronous, active high) returns the sequencer to idle; payload registers keep values.
`include "lcd_4bit_over_shift_register_defines.svh"
module lcd_4bit_over_shift_register (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_byte_value,
   input  logic [4:0] req_column,
   input  logic [2:0] req_row,
   input  logic [2:0] req_glyph_slot,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_serial_bit,
   output logic       rsp_frame_end,
   output logic       rsp_last
);
   import lcd4_pkg::*;

   seq_state_type           state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [BIT_IDX_W-1:0]    bit_ff, bit_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    rs_en_ff, rs_en_in;

   logic                    req_take;
   logic                    req_live;     // request produces output
   logic [7:0]              req_byte;
   logic                    rsp_take;
   ctrl_word_type           ctrl;
   logic                    frame_end;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Decode the request into the byte to send and whether anything goes out.
   always_comb begin
      req_live = 1'b0;
      req_byte = req_byte_value;
      unique case (req_func)
         FUNC_COMMAND, FUNC_DATA: begin
            req_live = 1'b1;
         end
         FUNC_CURSOR: begin
            req_live = (req_row >= 3'd1) && (req_row <= 3'd4);
            req_byte = CURSOR_BASE + row_offset(req_row) + {3'b000, req_column};
         end
         FUNC_CLEAR: begin
            req_live = 1'b1;
         end
         FUNC_GLYPH: begin
            req_live = 1'b1;
            req_byte = GLYPH_BASE + {2'b00, req_glyph_slot, 3'b000};
         end
         default: begin
            req_live = 1'b0;
         end
      endcase
   end

   // Fetch the control word of the current step.
   assign ctrl = ucode_rom(step_ff);

   lcd4_frame_gen u_frame_gen (
      .ctrl       (ctrl),
      .byte_value (byte_ff),
      .rs_en      (rs_en_ff),
      .bit_idx    (bit_ff),
      .serial_bit (rsp_serial_bit),
      .frame_end  (frame_end)
   );

   // Next state: start on a live request, stop after the last bit of a stop step.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE_STATE: begin
            if (req_take && req_live) begin
               state_in = RUN_STATE;
            end
         end
         RUN_STATE: begin
            if (rsp_take && frame_end && ctrl.stop) begin
               state_in = IDLE_STATE;
            end
         end
         default: state_in = IDLE_STATE;
      endcase
   end

   // Datapath and sequencer counters.
   always_comb begin
      step_in  = step_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      rs_en_in = rs_en_ff;
      if (req_take) begin
         // load the request and jump to its program entry
         byte_in  = req_byte;
         rs_en_in = (req_func == FUNC_DATA);
         step_in  = (req_func == FUNC_CLEAR) ? CLEAR_ENTRY : BYTE_ENTRY;
         bit_in   = '0;
      end else if (rsp_take) begin
         // advance one bit; at frame end advance the step unless it is a stop step
         bit_in = bit_ff + BIT_IDX_W'(1);
         if (frame_end && !ctrl.stop) begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   // Outputs: drive the handshake from the state, hold payload while stalled.
   always_comb begin
      rsp_valid     = (state_ff == RUN_STATE);
      req_stall     = (state_ff == RUN_STATE);
      rsp_frame_end = frame_end;
      rsp_last      = frame_end && ctrl.stop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
         step_ff  <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      rs_en_ff <= rs_en_in;
   end

   // The final bit of a request always closes a frame.
   `LCD4_ASSERT_NOW(a_last_ends_frame, clock, reset, rsp_valid && rsp_last, rsp_frame_end)
   // A request with no output leaves the sequencer idle.
   `LCD4_ASSERT_NEXT(a_dead_req_idle, clock, reset, req_take && !req_live, !rsp_valid)
   // Finishing a non-final frame moves to the next step and restarts the bit count.
   `LCD4_ASSERT_NEXT(a_step_advance, clock, reset, rsp_take && frame_end && !ctrl.stop, (bit_ff == '0) && (step_ff == $past(step_ff) + STEP_W'(1)))

endmodule

// ===== src/lcd4_frame_gen.sv =====
// Frame builder: forms the current frame from the control word and picks one bit.
module lcd4_frame_gen (
   input  lcd4_pkg::ctrl_word_type          ctrl,
   input  logic [7:0]                       byte_value,
   input  logic                             rs_en,
   input  logic [lcd4_pkg::BIT_IDX_W-1:0]   bit_idx,
   output logic                             serial_bit,
   output logic                             frame_end
);
   import lcd4_pkg::*;

   logic [3:0] nibble;
   logic [7:0] frame;

   always_comb begin
      nibble = ctrl.nib_low ? byte_value[3:0] : byte_value[7:4];
      if (ctrl.blank) begin
         frame = 8'h00;
      end else begin
         frame = {nibble, 1'b0, ctrl.set_e, 1'b0, ctrl.use_rs & rs_en};
      end
   end

   // MSB first
   assign serial_bit = frame[~bit_idx];
   assign frame_end  = (bit_idx == BIT_IDX_W'(FRAME_BITS - 1));

endmodule
